FILE: rtl/prbu_pkg.sv
package prbu_pkg;

    localparam int ChanW = 8;
    localparam int WideW = 16;
    localparam int OpW   = 5;

    localparam logic [OpW-1:0] OP_CLEAR      = 5'd0;
    localparam logic [OpW-1:0] OP_SRCOVER    = 5'd1;
    localparam logic [OpW-1:0] OP_DSTOVER    = 5'd2;
    localparam logic [OpW-1:0] OP_SRCIN      = 5'd3;
    localparam logic [OpW-1:0] OP_DSTIN      = 5'd4;
    localparam logic [OpW-1:0] OP_SRCOUT     = 5'd5;
    localparam logic [OpW-1:0] OP_DSTOUT     = 5'd6;
    localparam logic [OpW-1:0] OP_SRCATOP    = 5'd7;
    localparam logic [OpW-1:0] OP_DSTATOP    = 5'd8;
    localparam logic [OpW-1:0] OP_XOR        = 5'd9;
    localparam logic [OpW-1:0] OP_PLUS       = 5'd10;
    localparam logic [OpW-1:0] OP_MODULATE   = 5'd11;
    localparam logic [OpW-1:0] OP_SCREEN     = 5'd12;
    localparam logic [OpW-1:0] OP_MULTIPLY   = 5'd13;
    localparam logic [OpW-1:0] OP_DARKEN     = 5'd14;
    localparam logic [OpW-1:0] OP_LIGHTEN    = 5'd15;
    localparam logic [OpW-1:0] OP_DIFFERENCE = 5'd16;
    localparam logic [OpW-1:0] OP_EXCLUSION  = 5'd17;
    localparam logic [OpW-1:0] OP_HARDLIGHT  = 5'd18;
    localparam logic [OpW-1:0] OP_OVERLAY    = 5'd19;
    localparam logic [OpW-1:0] OP_PREMUL     = 5'd20;
    localparam logic [OpW-1:0] OP_SCALE      = 5'd21;
    localparam logic [OpW-1:0] OP_LERP       = 5'd22;

    typedef logic [WideW-1:0] w16_t;

    // Stage 1 products for one channel
    typedef struct packed {
        w16_t s;
        w16_t d;
        w16_t sda;   // s*da
        w16_t dsa;   // d*sa
        w16_t sia;   // s*(255-da)
        w16_t dis;   // d*(255-sa)
        w16_t sd;    // s*d
        w16_t sc;    // s*c
        w16_t dic;   // d*(255-c)
        w16_t hl;    // hard light / overlay body
    } prod_t;

    // divide by 255 approximation, 16-bit wrap
    function automatic w16_t div255(input w16_t v);
        w16_t t;
        t = v + 16'd255;
        return {8'd0, t[15:8]};
    endfunction

endpackage

FILE: rtl/prbu_mul.sv
// Stage 1: all products for one channel
module prbu_mul (
    input  logic                        clk,
    input  logic [prbu_pkg::OpW-1:0]    op,
    input  logic [prbu_pkg::ChanW-1:0]  s,
    input  logic [prbu_pkg::ChanW-1:0]  d,
    input  logic [prbu_pkg::ChanW-1:0]  sa,
    input  logic [prbu_pkg::ChanW-1:0]  da,
    input  logic [prbu_pkg::ChanW-1:0]  cov,
    output prbu_pkg::prod_t             prod_reg
);
    prbu_pkg::prod_t prod_next;
    prbu_pkg::w16_t  s16, d16, sa16, da16, c16, is16, ia16, ic16;
    prbu_pkg::w16_t  two_s, two_d, sel_b;
    logic            sel;

    always_comb
    begin
        s16  = {8'd0, s};
        d16  = {8'd0, d};
        sa16 = {8'd0, sa};
        da16 = {8'd0, da};
        c16  = {8'd0, cov};
        is16 = 16'd255 - sa16;
        ia16 = 16'd255 - da16;
        ic16 = 16'd255 - c16;
        two_s = {s16[14:0], 1'b0};
        two_d = {d16[14:0], 1'b0};
        sel = (op == prbu_pkg::OP_HARDLIGHT) ? (two_s <= sa16) : (two_d <= da16);
        // wrapped body: sel ? 2*s*d : sa*da - 2*(sa-s)*(da-d)
        if (sel)
            sel_b = 16'(two_s * d16);
        else
            sel_b = 16'(sa16 * da16) - 16'({(sa16 - s16), 1'b0} * (da16 - d16));
        prod_next.s   = s16;
        prod_next.d   = d16;
        prod_next.sda = 16'(s16 * da16);
        prod_next.dsa = 16'(d16 * sa16);
        prod_next.sia = 16'(s16 * ia16);
        prod_next.dis = 16'(d16 * is16);
        prod_next.sd  = 16'(s16 * d16);
        prod_next.sc  = 16'(s16 * c16);
        prod_next.dic = 16'(d16 * ic16);
        prod_next.hl  = sel_b;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end
endmodule

FILE: rtl/prbu_comb.sv
// Stages 2 and 3: sum and divide, then final add/sub and saturate
module prbu_comb (
    input  logic                        clk,
    input  logic [prbu_pkg::OpW-1:0]    op,
    input  logic                        alpha_lane,
    input  prbu_pkg::prod_t             prod,
    input  prbu_pkg::prod_t             prod_a,
    output logic [prbu_pkg::OpW-1:0]    op_reg,
    output logic [prbu_pkg::ChanW-1:0]  res_reg
);
    prbu_pkg::w16_t  pre_next, pre_reg, sd_sum_next, sd_sum_reg;
    prbu_pkg::w16_t  res;
    prbu_pkg::w16_t  mnv, mxv;
    logic [prbu_pkg::OpW-1:0] eop;

    // separable modes use source-over on alpha
    always_comb
    begin
        eop = op;
        if (alpha_lane && op >= prbu_pkg::OP_DARKEN && op <= prbu_pkg::OP_OVERLAY)
            eop = prbu_pkg::OP_SRCOVER;
        mnv = (prod.sda < prod.dsa) ? prod.sda : prod.dsa;
        mxv = (prod.sda > prod.dsa) ? prod.sda : prod.dsa;
        sd_sum_next = prod.s + prod.d;
        case (eop)
            prbu_pkg::OP_CLEAR:      pre_next = '0;
            prbu_pkg::OP_SRCOVER:    pre_next = prod.s + prbu_pkg::div255(prod.dis);
            prbu_pkg::OP_DSTOVER:    pre_next = prod.d + prbu_pkg::div255(prod.sia);
            prbu_pkg::OP_SRCIN:      pre_next = prbu_pkg::div255(prod.sda);
            prbu_pkg::OP_DSTIN:      pre_next = prbu_pkg::div255(prod.dsa);
            prbu_pkg::OP_SRCOUT:     pre_next = prbu_pkg::div255(prod.sia);
            prbu_pkg::OP_DSTOUT:     pre_next = prbu_pkg::div255(prod.dis);
            prbu_pkg::OP_SRCATOP:    pre_next = prbu_pkg::div255(prod.sda + prod.dis);
            prbu_pkg::OP_DSTATOP:    pre_next = prbu_pkg::div255(prod.dsa + prod.sia);
            prbu_pkg::OP_XOR:        pre_next = prbu_pkg::div255(prod.sia + prod.dis);
            prbu_pkg::OP_PLUS:       pre_next = '0;
            prbu_pkg::OP_MODULATE:   pre_next = prbu_pkg::div255(prod.sd);
            prbu_pkg::OP_SCREEN:     pre_next = prbu_pkg::div255(prod.sd);
            prbu_pkg::OP_MULTIPLY:
                pre_next = prbu_pkg::div255(prod.sia + prod.dis + prod.sd);
            prbu_pkg::OP_DARKEN:     pre_next = prbu_pkg::div255(mxv);
            prbu_pkg::OP_LIGHTEN:    pre_next = prbu_pkg::div255(mnv);
            prbu_pkg::OP_DIFFERENCE: pre_next = prbu_pkg::div255(mnv);
            prbu_pkg::OP_EXCLUSION:  pre_next = prbu_pkg::div255(prod.sd);
            prbu_pkg::OP_HARDLIGHT,
            prbu_pkg::OP_OVERLAY:
                pre_next = prbu_pkg::div255(prod.sia + prod.dis + prod.hl);
            prbu_pkg::OP_PREMUL:
                pre_next = alpha_lane ? prod.s : prbu_pkg::div255(prod_a.dsa);
            prbu_pkg::OP_SCALE:      pre_next = prbu_pkg::div255(prod.sc);
            prbu_pkg::OP_LERP:       pre_next = prbu_pkg::div255(prod.dic + prod.sc);
            default:                 pre_next = prod.s;
        endcase
    end

    always_ff @(posedge clk)
    begin
        pre_reg    <= pre_next;
        sd_sum_reg <= sd_sum_next;
        op_reg     <= eop;
    end

    // stage 3 final combine
    always_comb
    begin
        case (op_reg)
            prbu_pkg::OP_PLUS:
                res = (sd_sum_reg < 16'd255) ? sd_sum_reg : 16'd255;
            prbu_pkg::OP_SCREEN,
            prbu_pkg::OP_DARKEN,
            prbu_pkg::OP_LIGHTEN:    res = sd_sum_reg - pre_reg;
            prbu_pkg::OP_DIFFERENCE,
            prbu_pkg::OP_EXCLUSION:  res = sd_sum_reg - {pre_reg[14:0], 1'b0};
            default:                 res = pre_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= (res > 16'd255) ? 8'd255 : res[7:0];
    end
endmodule

FILE: rtl/premultiplied_rgba_blend_unit_top.sv
// Premultiplied RGBA blend unit. One pixel is accepted every clock (busy is
// never raised) and its result appears on out_* with done high after passing
// the input register, the 8x8 multiplier register, the sum and divide-by-255
// register and the final add, subtract and saturation register. The receiver
// cannot stall; each result is valid for one cycle only.
module premultiplied_rgba_blend_unit_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [prbu_pkg::OpW-1:0]    operation,
    input  logic [prbu_pkg::ChanW-1:0]  src_red,
    input  logic [prbu_pkg::ChanW-1:0]  src_green,
    input  logic [prbu_pkg::ChanW-1:0]  src_blue,
    input  logic [prbu_pkg::ChanW-1:0]  src_alpha,
    input  logic [prbu_pkg::ChanW-1:0]  dst_red,
    input  logic [prbu_pkg::ChanW-1:0]  dst_green,
    input  logic [prbu_pkg::ChanW-1:0]  dst_blue,
    input  logic [prbu_pkg::ChanW-1:0]  dst_alpha,
    input  logic [prbu_pkg::ChanW-1:0]  coverage,
    output logic                        done,
    output logic [prbu_pkg::ChanW-1:0]  out_red,
    output logic [prbu_pkg::ChanW-1:0]  out_green,
    output logic [prbu_pkg::ChanW-1:0]  out_blue,
    output logic [prbu_pkg::ChanW-1:0]  out_alpha
);
    logic [prbu_pkg::OpW-1:0]   op_reg, op1_reg;
    logic [prbu_pkg::ChanW-1:0] s_reg [4];
    logic [prbu_pkg::ChanW-1:0] d_reg [4];
    logic [prbu_pkg::ChanW-1:0] c_reg;
    logic [3:0]                 vld_reg;
    prbu_pkg::prod_t            prod [4];
    prbu_pkg::prod_t            prod_premul [4];
    logic [prbu_pkg::OpW-1:0]   op3 [4];
    logic [prbu_pkg::ChanW-1:0] res [4];

    assign busy = 1'b0;

    // valid travels with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[2:0], start};
    end

    // input register
    always_ff @(posedge clk)
    begin
        op_reg   <= operation;
        op1_reg  <= op_reg;
        s_reg[0] <= src_red;
        s_reg[1] <= src_green;
        s_reg[2] <= src_blue;
        s_reg[3] <= src_alpha;
        d_reg[0] <= dst_red;
        d_reg[1] <= dst_green;
        d_reg[2] <= dst_blue;
        d_reg[3] <= dst_alpha;
        c_reg    <= coverage;
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        prbu_mul u_mul (
            .clk(clk), .op(op_reg), .s(s_reg[i]), .d(d_reg[i]),
            .sa(s_reg[3]), .da(d_reg[3]), .cov(c_reg), .prod_reg(prod[i])
        );
        // premul color takes s*sa from the dsa slot of the premul products
        prbu_comb u_comb (
            .clk(clk), .op(op1_reg), .alpha_lane(i == 3), .prod(prod[i]),
            .prod_a(prod_premul[i]), .op_reg(op3[i]), .res_reg(res[i])
        );
    end

    // premul needs s*sa per color lane: s*sa equals dsa when d is replaced by s
    for (genvar j = 0; j < 4; j++)
    begin : g_pm
        prbu_mul u_pm (
            .clk(clk), .op(op_reg), .s(s_reg[j]), .d(s_reg[j]),
            .sa(s_reg[3]), .da(d_reg[3]), .cov(c_reg), .prod_reg(prod_premul[j])
        );
    end

    assign done      = vld_reg[3];
    assign out_red   = res[0];
    assign out_green = res[1];
    assign out_blue  = res[2];
    assign out_alpha = res[3];
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int NumRandom = 1700;
    localparam int Latency   = 4;
    localparam int IdleLimit = 2000;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [prbu_pkg::OpW-1:0] op;
        byte_t [3:0]    src;   // index 3 is alpha
        byte_t [3:0]    dst;
        byte_t          cov;
    } pixel_in_t;

    typedef struct {
        pixel_in_t   px;
        logic        fixed;
        byte_t [3:0] rgba;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [prbu_pkg::OpW-1:0] operation = '0;
    byte_t src_red = '0, src_green = '0, src_blue = '0, src_alpha = '0;
    byte_t dst_red = '0, dst_green = '0, dst_blue = '0, dst_alpha = '0;
    byte_t coverage = '0;
    logic done;
    byte_t out_red, out_green, out_blue, out_alpha;

    byte_t [3:0] blend_expected[$];
    int error_count = 0;
    int pixel_count = 0;
    int result_count = 0;
    int idle_cycles = 0;
    int op_hits[32];

    premultiplied_rgba_blend_unit_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // 16-bit wrapping helpers and divide by 255
    function automatic logic [15:0] div255w(logic [15:0] v);
        logic [15:0] t;
        t = v + 16'd255;
        return {8'd0, t[15:8]};
    endfunction

    function automatic logic [15:0] mulw(logic [15:0] a, logic [15:0] b);
        return a * b;
    endfunction

    // light body shared by hard light and overlay
    function automatic logic [15:0] light_term(logic [15:0] s, logic [15:0] d,
                                               logic [15:0] sa, logic [15:0] da,
                                               logic sel);
        logic [15:0] body;
        if (sel)
            body = mulw(mulw(16'd2, s), d);
        else
            body = mulw(sa, da) - mulw(mulw(16'd2, sa - s), da - d);
        return div255w(mulw(s, 16'd255 - da) + mulw(d, 16'd255 - sa) + body);
    endfunction

    function automatic logic [15:0] blend_chan(logic [prbu_pkg::OpW-1:0] op,
                                               logic [15:0] s, logic [15:0] d,
                                               logic [15:0] sa, logic [15:0] da);
        logic [15:0] is_, ia, m1, m2;
        is_ = 16'd255 - sa;
        ia  = 16'd255 - da;
        m1  = mulw(s, da);
        m2  = mulw(d, sa);
        case (op)
            prbu_pkg::OP_CLEAR:      return 16'd0;
            prbu_pkg::OP_SRCOVER:    return s + div255w(mulw(d, is_));
            prbu_pkg::OP_DSTOVER:    return d + div255w(mulw(s, ia));
            prbu_pkg::OP_SRCIN:      return div255w(m1);
            prbu_pkg::OP_DSTIN:      return div255w(m2);
            prbu_pkg::OP_SRCOUT:     return div255w(mulw(s, ia));
            prbu_pkg::OP_DSTOUT:     return div255w(mulw(d, is_));
            prbu_pkg::OP_SRCATOP:    return div255w(m1 + mulw(d, is_));
            prbu_pkg::OP_DSTATOP:    return div255w(m2 + mulw(s, ia));
            prbu_pkg::OP_XOR:        return div255w(mulw(s, ia) + mulw(d, is_));
            prbu_pkg::OP_PLUS:       return ((s + d) < 16'd255) ? s + d : 16'd255;
            prbu_pkg::OP_MODULATE:   return div255w(mulw(s, d));
            prbu_pkg::OP_SCREEN:     return s + d - div255w(mulw(s, d));
            prbu_pkg::OP_MULTIPLY:
                return div255w(mulw(s, ia) + mulw(d, is_) + mulw(s, d));
            prbu_pkg::OP_DARKEN:     return s + d - div255w((m1 > m2) ? m1 : m2);
            prbu_pkg::OP_LIGHTEN:    return s + d - div255w((m1 < m2) ? m1 : m2);
            prbu_pkg::OP_DIFFERENCE:
                return s + d - mulw(16'd2, div255w((m1 < m2) ? m1 : m2));
            prbu_pkg::OP_EXCLUSION:  return s + d - mulw(16'd2, div255w(mulw(s, d)));
            prbu_pkg::OP_HARDLIGHT:
                return light_term(s, d, sa, da, mulw(16'd2, s) <= sa);
            prbu_pkg::OP_OVERLAY:
                return light_term(s, d, sa, da, mulw(16'd2, d) <= da);
            default:                 return s;
        endcase
    endfunction

    function automatic byte_t [3:0] predict_blend(pixel_in_t p);
        logic [15:0] r[4];
        logic [15:0] sa, da, c, ic, s, d;
        byte_t [3:0] res;
        sa = {8'd0, p.src[3]};
        da = {8'd0, p.dst[3]};
        c  = {8'd0, p.cov};
        ic = 16'd255 - c;
        for (int i = 0; i < 4; i++)
        begin
            s = {8'd0, p.src[i]};
            d = {8'd0, p.dst[i]};
            if (p.op <= prbu_pkg::OP_OVERLAY)
                r[i] = blend_chan(p.op, s, d, sa, da);
            else if (p.op == prbu_pkg::OP_PREMUL)
                r[i] = div255w(mulw(s, sa));
            else if (p.op == prbu_pkg::OP_SCALE)
                r[i] = div255w(mulw(s, c));
            else if (p.op == prbu_pkg::OP_LERP)
                r[i] = div255w(mulw(d, ic) + mulw(s, c));
            else
                r[i] = s;
        end
        // separable modes: alpha is source-over; premul keeps alpha
        if (p.op >= prbu_pkg::OP_DARKEN && p.op <= prbu_pkg::OP_OVERLAY)
            r[3] = sa + div255w(mulw(da, 16'd255 - sa));
        else if (p.op == prbu_pkg::OP_PREMUL)
            r[3] = sa;
        for (int i = 0; i < 4; i++)
            res[i] = (r[i] < 16'd255) ? r[i][7:0] : 8'd255;
        return res;
    endfunction

    task automatic report_mismatch(string what, byte_t got, byte_t want);
        $display("%0t: %s mismatch: got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            byte_t [3:0] want;
            result_count++;
            if (blend_expected.size() == 0)
            begin
                $display("%0t: result with no transfer pending", $realtime);
                error_count++;
            end
            else
            begin
                want = blend_expected.pop_front();
                if (out_red !== want[0])   report_mismatch("red", out_red, want[0]);
                if (out_green !== want[1]) report_mismatch("green", out_green, want[1]);
                if (out_blue !== want[2])  report_mismatch("blue", out_blue, want[2]);
                if (out_alpha !== want[3]) report_mismatch("alpha", out_alpha, want[3]);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("watchdog expired");
            $display("premultiplied_rgba_blend_unit_top test failed");
            $finish;
        end
    end

    task automatic send_pixel(pixel_in_t p, byte_t [3:0] want, int gap_pct);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        operation <= p.op;
        src_red   <= p.src[0];
        src_green <= p.src[1];
        src_blue  <= p.src[2];
        src_alpha <= p.src[3];
        dst_red   <= p.dst[0];
        dst_green <= p.dst[1];
        dst_blue  <= p.dst[2];
        dst_alpha <= p.dst[3];
        coverage  <= p.cov;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        blend_expected.push_back(want);
        pixel_count++;
        op_hits[p.op]++;
        @(negedge clk);
    endtask

    function automatic pixel_in_t make_pixel(logic [prbu_pkg::OpW-1:0] op, byte_t s,
                                             byte_t sa, byte_t d, byte_t da, byte_t c);
        pixel_in_t p;
        p.op = op;
        p.src = {sa, s, s, s};
        p.dst = {da, d, d, d};
        p.cov = c;
        return p;
    endfunction

    function automatic pixel_in_t random_pixel();
        pixel_in_t p;
        p.op = ($urandom_range(9) == 0) ? prbu_pkg::OpW'($urandom_range(31))
                                        : prbu_pkg::OpW'($urandom_range(22));
        p.cov = byte_t'($urandom_range(255));
        p.src[3] = byte_t'($urandom_range(255));
        p.dst[3] = byte_t'($urandom_range(255));
        // mostly valid premultiplied color, some raw values to hit wraparound
        for (int i = 0; i < 3; i++)
        begin
            p.src[i] = ($urandom_range(3) == 0) ? byte_t'($urandom_range(255))
                                                : byte_t'($urandom_range(p.src[3]));
            p.dst[i] = ($urandom_range(3) == 0) ? byte_t'($urandom_range(255))
                                                : byte_t'($urandom_range(p.dst[3]));
        end
        // occasional extremes on alpha and coverage
        case ($urandom_range(7))
            0: p.src[3] = 8'd0;
            1: p.src[3] = 8'd255;
            2: p.dst[3] = 8'd255;
            3: p.cov = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
            default: ;
        endcase
        return p;
    endfunction

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        int gap_pct;

        // directed table: fixed expectations where obvious, else predicted
        rows.push_back('{make_pixel(prbu_pkg::OP_CLEAR, 8'd255, 8'd255, 8'd255,
                                    8'd255, 8'd255),
                         1'b1, {8'd0, 8'd0, 8'd0, 8'd0}});
        rows.push_back('{make_pixel(prbu_pkg::OP_SRCOVER, 8'd255, 8'd255, 8'd17,
                                    8'd200, 8'd0),
                         1'b1, {8'd255, 8'd255, 8'd255, 8'd255}});
        rows.push_back('{make_pixel(prbu_pkg::OP_SRCOVER, 8'd0, 8'd0, 8'd90,
                                    8'd90, 8'd0),
                         1'b1, {8'd90, 8'd90, 8'd90, 8'd90}});
        rows.push_back('{make_pixel(prbu_pkg::OP_PLUS, 8'd200, 8'd200, 8'd200,
                                    8'd200, 8'd0),
                         1'b1, {8'd255, 8'd255, 8'd255, 8'd255}});
        rows.push_back('{make_pixel(prbu_pkg::OP_SCALE, 8'd123, 8'd200, 8'd0,
                                    8'd0, 8'd0),
                         1'b1, {8'd0, 8'd0, 8'd0, 8'd0}});
        rows.push_back('{make_pixel(5'd31, 8'd77, 8'd150, 8'd3, 8'd4, 8'd5),
                         1'b1, {8'd150, 8'd77, 8'd77, 8'd77}});
        rows.push_back('{make_pixel(5'd23, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255),
                         1'b1, {8'd0, 8'd255, 8'd255, 8'd255}});
        for (int op = 2; op <= 22; op++)
            rows.push_back('{make_pixel(prbu_pkg::OpW'(op), 8'd180, 8'd100, 8'd200,
                                        8'd60, 8'd77),
                             1'b0, '0});
        // non-premultiplied extremes that wrap intermediates
        rows.push_back('{make_pixel(prbu_pkg::OP_HARDLIGHT, 8'd255, 8'd0, 8'd255,
                                    8'd0, 8'd0),
                         1'b0, '0});
        rows.push_back('{make_pixel(prbu_pkg::OP_OVERLAY, 8'd255, 8'd255, 8'd0,
                                    8'd255, 8'd0),
                         1'b0, '0});

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            send_pixel(row.px, row.fixed ? row.rgba : predict_blend(row.px), 0);
        end

        // random traffic in three idling phases
        for (int n = 0; n < NumRandom; n++)
        begin
            pixel_in_t p;
            if (n < NumRandom / 3)
                gap_pct = 24;
            else if (n < 2 * NumRandom / 3)
                gap_pct = 67;
            else
                gap_pct = 0;
            p = random_pixel();
            send_pixel(p, predict_blend(p), gap_pct);
        end
        start <= 1'b0;

        while (blend_expected.size() != 0)
            @(posedge clk);
        repeat (Latency + 4) @(posedge clk);

        $display("Sent %0d pixels, checked %0d results across all 32 operation codes.",
                 pixel_count, result_count);
        $display("Operation 0 and 31 counts: %0d, %0d", op_hits[0], op_hits[31]);
        if (error_count == 0)
            $display("premultiplied_rgba_blend_unit_top test passed");
        else
            $display("premultiplied_rgba_blend_unit_top test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/prbu_pkg.sv
rtl/prbu_mul.sv
rtl/prbu_comb.sv
rtl/premultiplied_rgba_blend_unit_top.sv
tb/sv/tb_top.sv
